// ===== src/axrmm_pkg.sv =====
// Shared constants and types for the tensor axis reduce (max / mean) block.
// Used by the divider, the top level and the checker; depends on nothing.
package axrmm_pkg;

    localparam int MAX_INNER  = 4096;
    localparam int IDX_W      = $clog2(MAX_INNER);
    localparam int CNT_W      = IDX_W + 1;
    localparam int LEN_W      = 16;
    localparam int SAMPLE_W   = 32;
    localparam int ACC_W      = 48;
    localparam int DIV_CNT_W  = $clog2(ACC_W);

    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCTION_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT      = 2'd2;

    localparam logic MODE_MEAN = 1'b0;
    localparam logic MODE_MAX  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

endpackage

// ===== src/axrmm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; no package dependency.
module axrmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/axrmm_div.sv =====
// Radix-2 restoring divider: signed 48-bit sum by unsigned 16-bit length,
// quotient truncated toward zero, one quotient bit per cycle. Uses axrmm_pkg.
module axrmm_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [axrmm_pkg::ACC_W-1:0]  dividend,
    input  logic [axrmm_pkg::LEN_W-1:0]         divisor,
    output logic                                done,
    output logic signed [axrmm_pkg::SAMPLE_W-1:0] quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [axrmm_pkg::DIV_CNT_W-1:0]   count_reg, count_next;
    logic [axrmm_pkg::LEN_W-1:0]       rem_reg, rem_next;
    logic [axrmm_pkg::ACC_W-1:0]       quo_reg, quo_next;
    logic [axrmm_pkg::LEN_W-1:0]       divisor_reg, divisor_next;
    logic                              neg_reg, neg_next;

    logic [axrmm_pkg::LEN_W:0]         trial;
    logic [axrmm_pkg::LEN_W:0]         diff;
    logic                              bit_set;
    logic [axrmm_pkg::SAMPLE_W-1:0]    quo_low;

    assign trial   = {rem_reg, quo_reg[axrmm_pkg::ACC_W-1]};
    assign diff    = trial - {1'b0, divisor_reg};
    assign bit_set = (trial >= {1'b0, divisor_reg});

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        if (start) begin
            busy_next    = 1'b1;
            count_next   = axrmm_pkg::DIV_CNT_W'(axrmm_pkg::ACC_W - 1);
            rem_next     = '0;
            neg_next     = dividend[axrmm_pkg::ACC_W-1];
            quo_next     = dividend[axrmm_pkg::ACC_W-1] ? 48'(-dividend) : dividend;
            divisor_next = divisor;
        end else if (busy_reg) begin
            rem_next = bit_set ? diff[axrmm_pkg::LEN_W-1:0] : trial[axrmm_pkg::LEN_W-1:0];
            quo_next = {quo_reg[axrmm_pkg::ACC_W-2:0], bit_set};
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        count_reg   <= count_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
    end

    assign quo_low  = quo_reg[axrmm_pkg::SAMPLE_W-1:0];
    assign done     = done_reg;
    assign quotient = neg_reg ? -quo_low : quo_low;

endmodule

// ===== src/axis_reduce_max_mean_core.sv =====
// Tensor single-axis reduction (running max or mean per inner position).
// Uses axrmm_pkg, axrmm_ram (column accumulators) and axrmm_div (mean).
//
// Usage:
//   s_* carries samples in row-major order: per outer block, reduction_length
//   rows of inner_count samples. m_* carries one result per sample of the last
//   row: the column max or the column sum / reduction_length (toward zero),
//   with its inner position. Registers are written on cfg_wr_en; any write to
//   a defined register restarts at row 0, position 0.
// Timing:
//   One sample at a time. An accepted sample does a registered RAM read of its
//   accumulator, then writes the new value back in the update state. On the
//   last row, max mode then passes to the emit state; mean mode first waits in
//   the divide state for the bit-serial divider, then passes to the emit state.
// Reset:
//   aresetn (sync, active low) clears counters, registers to defaults and
//   the output valid. Accumulator RAM is not cleared; the first row seeds it.
// Back-pressure:
//   The result sits in an output register. A new sample is taken while it
//   waits; the next result holds in the emit state until the register frees.
module axis_reduce_max_mean_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // tdata: sample[31:0]
    input  logic [axrmm_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: reduced_value[31:0], position[43:32], zero[47:44]
    output logic [axrmm_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_wr_en,
    input  logic [axrmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [axrmm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    axrmm_pkg::state_t state_reg, state_next;

    logic                               mode_reg;
    logic [axrmm_pkg::LEN_W-1:0]        len_reg;
    logic [axrmm_pkg::CNT_W-1:0]        cnt_reg;
    logic [axrmm_pkg::IDX_W-1:0]        inner_index_reg, inner_index_next;
    logic [axrmm_pkg::LEN_W-1:0]        row_index_reg, row_index_next;

    logic signed [axrmm_pkg::SAMPLE_W-1:0] sample_reg;
    logic [axrmm_pkg::IDX_W-1:0]        pos_reg;
    logic                               first_reg;
    logic                               last_reg;
    logic signed [axrmm_pkg::SAMPLE_W-1:0] result_reg, result_next;

    logic                               m_tvalid_reg, m_tvalid_next;
    logic [axrmm_pkg::M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic [axrmm_pkg::LEN_W-1:0]        len_eff;
    logic [axrmm_pkg::CNT_W-1:0]        cnt_eff;
    logic [axrmm_pkg::IDX_W-1:0]        idx_cur;
    logic [axrmm_pkg::LEN_W-1:0]        row_cur;
    logic [axrmm_pkg::CNT_W-1:0]        idx_inc;
    logic [axrmm_pkg::LEN_W:0]          row_inc;
    logic                               accept;
    logic                               cfg_hit;

    logic signed [axrmm_pkg::ACC_W-1:0] acc_rd;
    logic signed [axrmm_pkg::ACC_W-1:0] sample_ext;
    logic signed [axrmm_pkg::ACC_W-1:0] acc_new;
    logic                               acc_wr_en;

    logic                               div_start;
    logic                               div_done;
    logic signed [axrmm_pkg::SAMPLE_W-1:0] div_quo;

    assign len_eff = (len_reg == '0) ? axrmm_pkg::LEN_W'(1) : len_reg;
    assign cnt_eff = (cnt_reg == '0) ? axrmm_pkg::CNT_W'(1) :
                     (cnt_reg > axrmm_pkg::CNT_W'(axrmm_pkg::MAX_INNER)) ?
                     axrmm_pkg::CNT_W'(axrmm_pkg::MAX_INNER) : cnt_reg;
    assign idx_cur = ({1'b0, inner_index_reg} >= cnt_eff) ? '0 : inner_index_reg;
    assign row_cur = (row_index_reg >= len_eff) ? '0 : row_index_reg;
    assign idx_inc = {1'b0, idx_cur} + 1'b1;
    assign row_inc = {1'b0, row_cur} + 1'b1;

    assign s_tready = (state_reg == axrmm_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cfg_hit  = cfg_wr_en && (cfg_index == axrmm_pkg::CFG_REDUCE_MODE ||
                                    cfg_index == axrmm_pkg::CFG_REDUCTION_LENGTH ||
                                    cfg_index == axrmm_pkg::CFG_INNER_COUNT);

    always_comb begin
        inner_index_next = inner_index_reg;
        row_index_next   = row_index_reg;
        if (cfg_hit) begin
            inner_index_next = '0;
            row_index_next   = '0;
        end else if (accept) begin
            if (idx_inc >= cnt_eff) begin
                inner_index_next = '0;
                row_index_next   = (row_inc >= {1'b0, len_eff}) ? '0 :
                                   row_inc[axrmm_pkg::LEN_W-1:0];
            end else begin
                inner_index_next = idx_inc[axrmm_pkg::IDX_W-1:0];
                row_index_next   = row_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= axrmm_pkg::MODE_MEAN;
            len_reg  <= axrmm_pkg::LEN_W'(1);
            cnt_reg  <= axrmm_pkg::CNT_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                axrmm_pkg::CFG_REDUCE_MODE:      mode_reg <= cfg_wdata[0];
                axrmm_pkg::CFG_REDUCTION_LENGTH: len_reg  <= cfg_wdata;
                axrmm_pkg::CFG_INNER_COUNT:      cnt_reg  <= cfg_wdata[axrmm_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    axrmm_ram #(
        .WIDTH (axrmm_pkg::ACC_W),
        .DEPTH (axrmm_pkg::MAX_INNER)
    ) u_acc_ram (
        .aclk    (aclk),
        .wr_en   (acc_wr_en),
        .wr_addr (pos_reg),
        .wr_data (acc_new),
        .rd_addr (idx_cur),
        .rd_data (acc_rd)
    );

    assign sample_ext = {{(axrmm_pkg::ACC_W - axrmm_pkg::SAMPLE_W){sample_reg[axrmm_pkg::SAMPLE_W-1]}},
                         sample_reg};

    always_comb begin
        if (first_reg) begin
            acc_new = sample_ext;
        end else if (mode_reg == axrmm_pkg::MODE_MAX) begin
            acc_new = (sample_ext > acc_rd) ? sample_ext : acc_rd;
        end else begin
            acc_new = acc_rd + sample_ext;
        end
    end

    assign acc_wr_en = (state_reg == axrmm_pkg::ST_UPDATE);
    assign div_start = acc_wr_en && last_reg && (mode_reg == axrmm_pkg::MODE_MEAN);

    axrmm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_new),
        .divisor  (len_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next    = state_reg;
        result_next   = result_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            axrmm_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = axrmm_pkg::ST_UPDATE;
                end
            end
            axrmm_pkg::ST_UPDATE: begin
                if (!last_reg) begin
                    state_next = axrmm_pkg::ST_IDLE;
                end else if (mode_reg == axrmm_pkg::MODE_MAX) begin
                    result_next = acc_new[axrmm_pkg::SAMPLE_W-1:0];
                    state_next  = axrmm_pkg::ST_EMIT;
                end else begin
                    state_next = axrmm_pkg::ST_DIVIDE;
                end
            end
            axrmm_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    result_next = div_quo;
                    state_next  = axrmm_pkg::ST_EMIT;
                end
            end
            axrmm_pkg::ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(axrmm_pkg::M_TDATA_W - axrmm_pkg::SAMPLE_W
                                       - axrmm_pkg::IDX_W){1'b0}}, pos_reg, result_reg};
                    state_next    = axrmm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = axrmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= axrmm_pkg::ST_IDLE;
            inner_index_reg <= '0;
            row_index_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            inner_index_reg <= inner_index_next;
            row_index_reg   <= row_index_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        if (accept) begin
            sample_reg <= s_tdata;
            pos_reg    <= idx_cur;
            first_reg  <= (row_cur == '0);
            last_reg   <= (row_cur == len_eff - 1'b1);
        end
        result_reg  <= result_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== src/axrmm_chk.sv =====
// Port-level checker for axis_reduce_max_mean_core, attached by bind.
// Uses axrmm_pkg for widths.
module axrmm_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic [axrmm_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [axrmm_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one request in flight: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    // drop output valid on reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[axrmm_pkg::M_TDATA_W-1:axrmm_pkg::SAMPLE_W+axrmm_pkg::IDX_W] == '0)
        else $error("nonzero padding in result");

endmodule

bind axis_reduce_max_mean_core axrmm_chk u_axrmm_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ===== tb/sv/tb_axis_reduce_max_mean_core.sv =====
// Self-checking testbench for axis_reduce_max_mean_core: a directed table, extreme
// settings and random phases, each result checked against the table or a behavioral reducer.
// Depends on axrmm_pkg and the core RTL only.
module tb_axis_reduce_max_mean_core;
    import axrmm_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned QUIET_CYCLES  = 100;
    localparam int unsigned RANDOM_ITEMS  = 200;
    localparam int unsigned LONG_ROWS     = 128;
    localparam int unsigned WIDE_ITEMS    = 40;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic [31:0] reduced;
        logic [11:0] position;
    } column_result_t;

    typedef enum logic {STEP_WRITE, STEP_SAMPLE} step_kind_t;
    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

    typedef struct {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [15:0]          reg_data;
        logic [31:0]          sample;
        bit                   typed;
        column_result_t       want;
    } directed_step_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // reducer state
    logic signed [47:0]     column_acc [MAX_INNER];
    logic                   mode_q;
    logic [15:0]            len_q;
    logic [12:0]            cnt_q;
    int unsigned            col_pos;
    int unsigned            row_pos;

    column_result_t         expected_columns [$];
    column_result_t         monitor_want;
    directed_step_t         directed_steps [$];

    int unsigned            cycle_count       = 0;
    int unsigned            column_mismatches = 0;
    int unsigned            results_checked   = 0;
    int unsigned            samples_sent      = 0;
    int unsigned            reg_writes        = 0;
    int unsigned            random_items      = 0;
    int unsigned            burst_left        = 0;
    int unsigned            rx_hold_left      = 0;
    bit                     tx_gaps_on        = 1'b0;
    rx_style_t              rx_style          = RX_ALWAYS;

    axis_reduce_max_mean_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("axis_reduce_max_mean_core verification failed");
            $finish;
        end
    end

    initial begin : rx_pacing
        int unsigned beat;
        beat = 0;
        forever begin
            @(posedge aclk);
            beat++;
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_style)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= ((beat % 7) < 5);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (expected_columns.size() == 0) begin
                column_mismatches++;
                if (column_mismatches <= MAX_REPORTS)
                    $display("unexpected result: value=%h position=%0d",
                             m_tdata[31:0], m_tdata[43:32]);
            end else begin
                monitor_want = expected_columns.pop_front();
                if (m_tdata[31:0] !== monitor_want.reduced ||
                    m_tdata[43:32] !== monitor_want.position) begin
                    column_mismatches++;
                    if (column_mismatches <= MAX_REPORTS)
                        $display("mismatch: value exp %h got %h, position exp %0d got %0d",
                                 monitor_want.reduced, m_tdata[31:0],
                                 monitor_want.position, m_tdata[43:32]);
                end
            end
        end
    end

    function automatic bit reduce_column_sample(input logic [31:0] raw,
                                                output column_result_t res);
        logic [15:0]        len_eff;
        int unsigned        cnt_eff;
        int unsigned        idx;
        logic signed [47:0] s_ext;
        logic signed [47:0] acc;
        logic signed [47:0] quo;
        bit                 produced;
        len_eff  = (len_q == '0) ? 16'd1 : len_q;
        cnt_eff  = (cnt_q == '0) ? 1 : ((cnt_q > MAX_INNER) ? MAX_INNER : cnt_q);
        idx      = col_pos;
        produced = 1'b0;
        res      = '0;
        if (idx >= cnt_eff) idx = 0;
        if (row_pos >= len_eff) row_pos = 0;
        s_ext = {{16{raw[31]}}, raw};
        if (row_pos == 0) begin
            acc = s_ext;
        end else begin
            acc = column_acc[idx];
            if (mode_q == MODE_MAX) begin
                if (s_ext > acc) acc = s_ext;
            end else begin
                acc = acc + s_ext;
            end
        end
        column_acc[idx] = acc;
        if (row_pos == len_eff - 1) begin
            quo = acc / $signed({32'd0, len_eff});
            res.reduced  = (mode_q == MODE_MAX) ? acc[31:0] : quo[31:0];
            res.position = idx[11:0];
            produced     = 1'b1;
        end
        idx++;
        if (idx >= cnt_eff) begin
            idx = 0;
            row_pos++;
            if (row_pos >= len_eff) row_pos = 0;
        end
        col_pos = idx;
        return produced;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        bit known;
        known = 1'b1;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_REDUCE_MODE:      mode_q = data[0];
            CFG_REDUCTION_LENGTH: len_q  = data;
            CFG_INNER_COUNT:      cnt_q  = data[12:0];
            default:              known  = 1'b0;
        endcase
        if (known) begin
            col_pos = 0;
            row_pos = 0;
        end
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic send_sample(input logic [31:0] value, input bit typed = 1'b0,
                               input column_result_t want = '0);
        int unsigned    gap;
        column_result_t res;
        if (burst_left == 0) begin
            gap = tx_gaps_on ? $urandom_range(1, 8) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tdata  <= value;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        if (reduce_column_sample(value, res)) begin
            if (typed) res = want;
            expected_columns.push_back(res);
        end
    endtask

    task automatic drain_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (expected_columns.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($signed($urandom_range(0, 16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic directed_step_t reg_step(input logic [CFG_IDX_W-1:0] idx,
                                                input logic [15:0] data);
        directed_step_t st;
        st          = '{kind: STEP_WRITE, default: '0};
        st.reg_idx  = idx;
        st.reg_data = data;
        return st;
    endfunction

    function automatic directed_step_t sample_step(input logic [31:0] s, input bit typed = 1'b0,
                                                   input logic [31:0] v = '0,
                                                   input logic [11:0] p = '0);
        directed_step_t st;
        st        = '{kind: STEP_SAMPLE, default: '0};
        st.sample = s;
        st.typed  = typed;
        st.want   = '{reduced: v, position: p};
        return st;
    endfunction

    initial begin : stimulus
        logic        mode_sel;
        logic [15:0] len_sel;
        logic [15:0] cnt_sel;
        int unsigned len_e;
        int unsigned cnt_e;
        int unsigned n_items;

        mode_q  = MODE_MEAN;
        len_q   = 16'd1;
        cnt_q   = 13'd1;
        col_pos = 0;
        row_pos = 0;

        // after reset: mean over one row is the sample itself
        directed_steps.push_back(sample_step(32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0));
        directed_steps.push_back(sample_step(32'h8000_0000, 1, 32'h8000_0000, 0));
        // zero length and zero inner count act as one
        directed_steps.push_back(reg_step(CFG_REDUCE_MODE, 16'd1));
        directed_steps.push_back(reg_step(CFG_REDUCTION_LENGTH, 16'd0));
        directed_steps.push_back(reg_step(CFG_INNER_COUNT, 16'd0));
        directed_steps.push_back(sample_step(32'h0001_0000, 1, 32'h0001_0000, 0));
        directed_steps.push_back(sample_step(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0));
        // max over two rows of three
        directed_steps.push_back(reg_step(CFG_REDUCTION_LENGTH, 16'd2));
        directed_steps.push_back(reg_step(CFG_INNER_COUNT, 16'd3));
        directed_steps.push_back(sample_step(32'h8000_0000));
        directed_steps.push_back(sample_step(32'h7FFF_FFFF));
        directed_steps.push_back(sample_step(32'h0000_0005));
        directed_steps.push_back(sample_step(32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0));
        directed_steps.push_back(sample_step(32'h8000_0000, 1, 32'h7FFF_FFFF, 1));
        directed_steps.push_back(sample_step(32'hFFFF_FFFF, 1, 32'h0000_0005, 2));
        // mean, truncation toward zero
        directed_steps.push_back(reg_step(CFG_REDUCE_MODE, 16'd0));
        directed_steps.push_back(sample_step(32'hFFFF_FFFD));
        directed_steps.push_back(sample_step(32'h7FFF_FFFF));
        directed_steps.push_back(sample_step(32'h8000_0000));
        directed_steps.push_back(sample_step(32'h0000_0000, 1, 32'hFFFF_FFFF, 0));
        directed_steps.push_back(sample_step(32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1));
        directed_steps.push_back(sample_step(32'h8000_0000, 1, 32'h8000_0000, 2));
        // write in the middle of a block restarts it
        directed_steps.push_back(sample_step(32'd10));
        directed_steps.push_back(sample_step(32'd20));
        directed_steps.push_back(reg_step(CFG_INNER_COUNT, 16'd2));
        directed_steps.push_back(sample_step(32'd100));
        directed_steps.push_back(sample_step(32'hFFFF_FF9C));
        directed_steps.push_back(sample_step(32'h0000_012D, 1, 32'h0000_00C8, 0));
        directed_steps.push_back(sample_step(32'hFFFF_FED3, 1, 32'hFFFF_FF38, 1));
        // write to an undefined index leaves the block where it is
        directed_steps.push_back(sample_step(32'h0001_8000));
        directed_steps.push_back(sample_step(32'hFFFE_8000));
        directed_steps.push_back(reg_step(CFG_UNUSED_IDX, 16'hFFFF));
        directed_steps.push_back(sample_step(32'h0000_8000));
        directed_steps.push_back(sample_step(32'h7FFF_FFFF));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_gaps_on = 1'b1;
        rx_style   = RX_RANDOM;
        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_WRITE) begin
                drain_results();
                write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_data);
            end else begin
                send_sample(directed_steps[i].sample, directed_steps[i].typed,
                            directed_steps[i].want);
            end
        end

        // long axis: full-scale negative sum over many rows
        drain_results();
        write_reg(CFG_REDUCE_MODE, 16'd0);
        write_reg(CFG_REDUCTION_LENGTH, 16'(LONG_ROWS));
        write_reg(CFG_INNER_COUNT, 16'd1);
        tx_gaps_on = 1'b0;
        rx_style   = RX_ALWAYS;
        repeat (LONG_ROWS) send_sample(32'h8000_0000);

        // inner count above the limit, one row per block
        drain_results();
        write_reg(CFG_REDUCE_MODE, 16'd1);
        write_reg(CFG_REDUCTION_LENGTH, 16'd1);
        write_reg(CFG_INNER_COUNT, 16'h1FFF);
        tx_gaps_on = 1'b1;
        rx_style   = RX_PATTERN;
        repeat (WIDE_ITEMS) send_sample(random_sample());

        // hold the receiver while the sender keeps offering, so the block backs up
        drain_results();
        write_reg(CFG_REDUCE_MODE, 16'd0);
        write_reg(CFG_REDUCTION_LENGTH, 16'd1);
        write_reg(CFG_INNER_COUNT, 16'd4);
        tx_gaps_on   = 1'b0;
        rx_style     = RX_ALWAYS;
        rx_hold_left = 300;
        repeat (60) send_sample(random_sample());
        random_items += 60;

        while (random_items < RANDOM_ITEMS) begin
            drain_results();
            mode_sel = $urandom_range(0, 1);
            case ($urandom_range(0, 9))
                0:       len_sel = 16'd0;
                1:       len_sel = 16'd1;
                default: len_sel = 16'($urandom_range(2, 6));
            endcase
            cnt_sel = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
            if ($urandom_range(0, 3) == 0) cnt_sel[15:13] = 3'($urandom_range(1, 7));
            write_reg(CFG_REDUCE_MODE, {15'($urandom), mode_sel});
            write_reg(CFG_REDUCTION_LENGTH, len_sel);
            write_reg(CFG_INNER_COUNT, cnt_sel);
            len_e   = (len_sel == 0) ? 1 : len_sel;
            cnt_e   = (cnt_sel[12:0] == 0) ? 1 : cnt_sel[12:0];
            n_items = len_e * cnt_e * $urandom_range(1, 3);
            if ($urandom_range(0, 4) == 0) n_items += $urandom_range(1, len_e * cnt_e);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_style   = rx_style_t'($urandom_range(0, 2));
            repeat (n_items) send_sample(random_sample());
            random_items += n_items;
        end

        drain_results();
        $display("run covered %0d samples and %0d register writes, %0d results checked",
                 samples_sent, reg_writes, results_checked);
        $display("mean and max, axis lengths 0 to %0d, inner counts 0 to 8191, stalls",
                 LONG_ROWS);
        if (column_mismatches == 0) begin
            $display("axis_reduce_max_mean_core verification clean");
        end else begin
            $display("%0d mismatches", column_mismatches);
            $display("axis_reduce_max_mean_core verification failed");
        end
        $finish;
    end

endmodule
